// ===== design/encd_pkg.sv =====
// encd_pkg: shared types, constants and helpers for the nearest-car dispatch block.
// No dependencies; imported by every module under design/.
`default_nettype none
package encd_pkg;

    localparam int MAX_CARS    = 8;
    localparam int FLOOR_BITS  = 8;
    localparam int TRAVEL_BITS = 24;

    localparam int CAR_BITS  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CNT_W     = $clog2(MAX_CARS + 1);
    localparam int CAR_OUT_W = 3;
    localparam int ADD_W     = FLOOR_BITS + 1;

    localparam int TOP_FLOOR_W = 8;
    localparam int CAR_COUNT_W = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [TOP_FLOOR_W-1:0] TOP_FLOOR_RST = 8'd255;
    localparam logic [CAR_COUNT_W-1:0] CAR_COUNT_RST = 4'd8;

    // register select is paddr[2]
    localparam logic REG_TOP_FLOOR = 1'b0;
    localparam logic REG_CAR_COUNT = 1'b1;

    typedef struct packed {
        logic [FLOOR_BITS-1:0]  floor;
        logic [TRAVEL_BITS-1:0] travel;
    } car_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_UPDATE,
        ST_DONE
    } state_t;

    function automatic logic [FLOOR_BITS-1:0] floor_dist(
        input logic [FLOOR_BITS-1:0] a,
        input logic [FLOOR_BITS-1:0] b
    );
        floor_dist = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

// ===== design/encd_cell.sv =====
// encd_cell: one car slot of the rotating car ring (floor and travel total).
// Depends on encd_pkg for car_t.
`default_nettype none
module encd_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire encd_pkg::car_t car_in,
    output encd_pkg::car_t     car_out
);
    import encd_pkg::*;

    car_t car_reg;
    car_t car_next;

    always_comb
    begin
        car_next = shift ? car_in : car_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_reg <= '0;
        end
        else
        begin
            car_reg <= car_next;
        end
    end

    assign car_out = car_reg;

endmodule
`default_nettype wire

// ===== design/elevator_nearest_car_dispatch.sv =====
// elevator_nearest_car_dispatch: top level, APB registers, control FSM, car ring.
// Depends on encd_pkg and encd_cell.
//
// A request is taken when start is high and busy is low. The cars sit in a ring
// of MAX_CARS cells that rotates one slot per cycle past a single compare unit:
// one full turn finds the nearest car, a prep step forms the added distance, a
// second turn applies the move and finds the least-travel car. The result is
// shown on the result ports for one cycle with done high after the second turn;
// busy stays high through that cycle and falls in the idle state that follows,
// where the next request can be taken. done cannot be held off; the receiver
// must take the beat in that cycle. Rejected requests take the same time.
`default_nettype none
module elevator_nearest_car_dispatch (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [encd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [encd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [encd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [encd_pkg::FLOOR_BITS-1:0]     origin_floor,
    input  wire logic [encd_pkg::FLOOR_BITS-1:0]     dest_floor,
    output logic                                     done,
    output logic                                     accepted,
    output logic      [encd_pkg::CAR_OUT_W-1:0]      chosen_car,
    output logic      [encd_pkg::FLOOR_BITS-1:0]     start_floor,
    output logic      [encd_pkg::TRAVEL_BITS-1:0]    car_travel,
    output logic      [encd_pkg::CAR_OUT_W-1:0]      least_travel_car,
    output logic      [encd_pkg::TRAVEL_BITS-1:0]    least_travel
);
    import encd_pkg::*;

    // configuration
    logic [TOP_FLOOR_W-1:0] top_floor_reg;
    logic [CAR_COUNT_W-1:0] car_count_reg;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_floor_reg <= TOP_FLOOR_RST;
            car_count_reg <= CAR_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TOP_FLOOR: top_floor_reg <= pwdata[TOP_FLOOR_W-1:0];
                REG_CAR_COUNT: car_count_reg <= pwdata[CAR_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TOP_FLOOR: prdata = APB_DATA_W'(top_floor_reg);
            REG_CAR_COUNT: prdata = APB_DATA_W'(car_count_reg);
            default:       prdata = '0;
        endcase
        if (paddr[1:0] != 2'b00)
        begin
            prdata = '0;
        end
    end

    // control
    state_t state_reg;
    state_t state_next;
    logic [CAR_BITS-1:0] cnt_reg;
    logic [CAR_BITS-1:0] cnt_next;
    logic cnt_last;
    logic take;
    logic shift;
    logic scan_en;
    logic upd_en;
    logic prep_en;

    assign take     = start && !busy;
    assign cnt_last = (cnt_reg == CAR_BITS'(MAX_CARS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SCAN;
            ST_SCAN:   if (cnt_last) state_next = ST_PREP;
            ST_PREP:   state_next = ST_UPDATE;
            ST_UPDATE: if (cnt_last) state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy    = 1'b1;
        done    = 1'b0;
        scan_en = 1'b0;
        upd_en  = 1'b0;
        prep_en = 1'b0;
        case (state_reg)
            ST_IDLE:   busy    = 1'b0;
            ST_SCAN:   scan_en = 1'b1;
            ST_PREP:   prep_en = 1'b1;
            ST_UPDATE: upd_en  = 1'b1;
            ST_DONE:   done    = 1'b1;
            default:   busy    = 1'b0;
        endcase
    end

    assign shift = scan_en || upd_en;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take || prep_en)
        begin
            cnt_next = '0;
        end
        else if (shift)
        begin
            cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // car ring: cell 0 is the head, contents move toward it
    car_t ring[MAX_CARS];
    car_t head;
    car_t feed;

    assign head = ring[0];

    generate
        for (genvar i = 0; i < MAX_CARS; i++)
        begin : g_cell
            if (i == MAX_CARS - 1)
            begin : g_tail
                encd_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (shift),
                    .car_in  (feed),
                    .car_out (ring[i])
                );
            end
            else
            begin : g_body
                encd_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (shift),
                    .car_in  (ring[i+1]),
                    .car_out (ring[i])
                );
            end
        end
    endgenerate

    // request and datapath registers
    logic                   valid_reg;
    logic                   valid_next;
    logic [CNT_W-1:0]       ncars_reg;
    logic [CNT_W-1:0]       ncars_next;
    logic [FLOOR_BITS-1:0]  origin_reg;
    logic [FLOOR_BITS-1:0]  dest_reg;
    logic [FLOOR_BITS-1:0]  trip_reg;
    logic [FLOOR_BITS-1:0]  best_reg;
    logic [FLOOR_BITS-1:0]  best_next;
    logic [CAR_BITS-1:0]    pick_reg;
    logic [CAR_BITS-1:0]    pick_next;
    logic [TRAVEL_BITS-1:0] pick_trv_reg;
    logic [TRAVEL_BITS-1:0] pick_trv_next;
    logic [ADD_W-1:0]       add_reg;
    logic [FLOOR_BITS-1:0]  start_reg;
    logic [FLOOR_BITS-1:0]  start_next;
    logic [TRAVEL_BITS-1:0] ctrv_reg;
    logic [TRAVEL_BITS-1:0] ctrv_next;
    logic [CAR_BITS-1:0]    lcar_reg;
    logic [CAR_BITS-1:0]    lcar_next;
    logic [TRAVEL_BITS-1:0] least_reg;
    logic [TRAVEL_BITS-1:0] least_next;

    logic [31:0]            cc32;
    logic                   active;
    logic [FLOOR_BITS-1:0]  d_head;
    logic [TRAVEL_BITS:0]   sum;
    logic [TRAVEL_BITS-1:0] tsat;
    logic [TRAVEL_BITS-1:0] tv;
    logic                   hit;

    assign cc32   = 32'(car_count_reg);
    assign active = (CNT_W'(cnt_reg) < ncars_reg);
    assign d_head = floor_dist(head.floor, origin_reg);
    assign sum    = {1'b0, head.travel} + (TRAVEL_BITS + 1)'(add_reg);
    assign tsat   = sum[TRAVEL_BITS] ? {TRAVEL_BITS{1'b1}} : sum[TRAVEL_BITS-1:0];
    assign hit    = valid_reg && (cnt_reg == pick_reg);
    assign tv     = hit ? tsat : head.travel;

    always_comb
    begin
        valid_next    = valid_reg;
        ncars_next    = ncars_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        pick_trv_next = pick_trv_reg;
        start_next    = start_reg;
        ctrv_next     = ctrv_reg;
        lcar_next     = lcar_reg;
        least_next    = least_reg;
        feed          = head;

        if (take)
        begin
            valid_next = !((origin_floor > top_floor_reg) || (dest_floor > top_floor_reg)
                           || (dest_floor == origin_floor));
            if (cc32 == 32'd0)
            begin
                ncars_next = CNT_W'(1);
            end
            else if (cc32 > 32'(MAX_CARS))
            begin
                ncars_next = CNT_W'(MAX_CARS);
            end
            else
            begin
                ncars_next = CNT_W'(cc32);
            end
        end

        if (scan_en && active)
        begin
            if (cnt_reg == '0)
            begin
                best_next     = d_head;
                pick_next     = '0;
                pick_trv_next = head.travel;
            end
            else if ((d_head < best_reg)
                     || ((d_head == best_reg) && (head.travel < pick_trv_reg)))
            begin
                best_next     = d_head;
                pick_next     = cnt_reg;
                pick_trv_next = head.travel;
            end
        end

        if (upd_en)
        begin
            if (hit)
            begin
                feed.floor  = dest_reg;
                feed.travel = tsat;
                start_next  = head.floor;
                ctrv_next   = tsat;
            end
            if (active)
            begin
                if (cnt_reg == '0)
                begin
                    least_next = tv;
                    lcar_next  = '0;
                end
                else if (tv < least_reg)
                begin
                    least_next = tv;
                    lcar_next  = cnt_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ncars_reg <= CNT_W'(1);
        end
        else
        begin
            valid_reg <= valid_next;
            ncars_reg <= ncars_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            origin_reg <= origin_floor;
            dest_reg   <= dest_floor;
            trip_reg   <= floor_dist(origin_floor, dest_floor);
        end
        if (prep_en)
        begin
            add_reg <= ADD_W'(best_reg) + ADD_W'(trip_reg);
        end
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        pick_trv_reg <= pick_trv_next;
        start_reg    <= start_next;
        ctrv_reg     <= ctrv_next;
        lcar_reg     <= lcar_next;
        least_reg    <= least_next;
    end

    // results
    assign accepted         = valid_reg;
    assign chosen_car       = valid_reg ? CAR_OUT_W'(pick_reg) : '0;
    assign start_floor      = valid_reg ? start_reg : '0;
    assign car_travel       = valid_reg ? ctrv_reg : '0;
    assign least_travel_car = CAR_OUT_W'(lcar_reg);
    assign least_travel     = least_reg;

endmodule
`default_nettype wire

// ===== design/encd_checker.sv =====
// encd_checker: port-level assertions for elevator_nearest_car_dispatch, and its bind.
// Depends on encd_pkg for port widths.
`default_nettype none
module encd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             done,
    input wire logic                             accepted,
    input wire logic [encd_pkg::CAR_OUT_W-1:0]   chosen_car,
    input wire logic [encd_pkg::FLOOR_BITS-1:0]  start_floor,
    input wire logic [encd_pkg::TRAVEL_BITS-1:0] car_travel,
    input wire logic [encd_pkg::TRAVEL_BITS-1:0] least_travel
);
    import encd_pkg::*;

    // a result beat only ends a busy period
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("busy period did not end after result beat");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("accepted request did not raise busy");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |-> (chosen_car == '0) && (start_floor == '0)
                                && (car_travel == '0))
        else $error("rejected result carries nonzero car fields");

    a_least_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> (least_travel <= car_travel))
        else $error("least travel above chosen car travel");

endmodule

bind elevator_nearest_car_dispatch encd_checker u_encd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .accepted     (accepted),
    .chosen_car   (chosen_car),
    .start_floor  (start_floor),
    .car_travel   (car_travel),
    .least_travel (least_travel)
);
`default_nettype wire

// ===== verif/elevator_nearest_car_dispatch_test.sv =====
// Self-checking testbench for elevator_nearest_car_dispatch: APB setup, ride requests,
// an in-bench dispatch predictor and a result checker. Depends on encd_pkg and the design.
`timescale 1ns / 1ps
module elevator_nearest_car_dispatch_test;
    import encd_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_TOP_FLOOR = {REG_TOP_FLOOR, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_CAR_COUNT = {REG_CAR_COUNT, 2'b00};
    localparam logic [TRAVEL_BITS-1:0] TRAVEL_SAT = {TRAVEL_BITS{1'b1}};

    typedef struct packed {
        logic                   took;
        logic [CAR_OUT_W-1:0]   car;
        logic [FLOOR_BITS-1:0]  from_floor;
        logic [TRAVEL_BITS-1:0] car_total;
        logic [CAR_OUT_W-1:0]   low_car;
        logic [TRAVEL_BITS-1:0] low_total;
    } dispatch_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   start = 1'b0;
    logic                   busy;
    logic [FLOOR_BITS-1:0]  origin_floor = '0;
    logic [FLOOR_BITS-1:0]  dest_floor = '0;
    logic                   done;
    logic                   accepted;
    logic [CAR_OUT_W-1:0]   chosen_car;
    logic [FLOOR_BITS-1:0]  start_floor;
    logic [TRAVEL_BITS-1:0] car_travel;
    logic [CAR_OUT_W-1:0]   least_travel_car;
    logic [TRAVEL_BITS-1:0] least_travel;

    // predictor state
    logic [FLOOR_BITS-1:0]  car_at [MAX_CARS];
    logic [TRAVEL_BITS-1:0] car_miles [MAX_CARS];
    logic [7:0]             top_reg;
    logic [3:0]             count_reg;

    dispatch_t dispatch_q [$];
    int  n_errors = 0;
    int  n_sent = 0;
    int  n_taken = 0;
    int  n_refused = 0;
    int  n_writes = 0;
    bit  burst_mode = 1'b0;
    bit  holding = 1'b0;

    elevator_nearest_car_dispatch dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .origin_floor(origin_floor),
        .dest_floor(dest_floor),
        .done(done),
        .accepted(accepted),
        .chosen_car(chosen_car),
        .start_floor(start_floor),
        .car_travel(car_travel),
        .least_travel_car(least_travel_car),
        .least_travel(least_travel)
    );

    always #10 clk = ~clk;

    initial
    begin
        #60_000_000;
        $display("elevator_nearest_car_dispatch_test: errors");
        $finish;
    end

    function automatic logic [FLOOR_BITS-1:0] floors_apart(
        input logic [FLOOR_BITS-1:0] a,
        input logic [FLOOR_BITS-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic dispatch_t predict_dispatch(
        input logic [FLOOR_BITS-1:0] o,
        input logic [FLOOR_BITS-1:0] d
    );
        dispatch_t r;
        int n;
        int pick;
        int low;
        logic [FLOOR_BITS-1:0] best;
        logic [FLOOR_BITS-1:0] dd;
        logic [TRAVEL_BITS+1:0] sum;
        r = '0;
        n = (count_reg == 0) ? 1 : (count_reg > MAX_CARS) ? MAX_CARS : int'(count_reg);
        if (!(o > top_reg || d > top_reg || d == o))
        begin
            pick = 0;
            best = floors_apart(car_at[0], o);
            for (int i = 1; i < n; i++)
            begin
                dd = floors_apart(car_at[i], o);
                if (dd < best)
                begin
                    best = dd;
                    pick = i;
                end
                else if (dd == best && car_miles[i] < car_miles[pick])
                    pick = i;
            end
            sum = car_miles[pick] + best + floors_apart(o, d);
            if (sum > TRAVEL_SAT)
                sum = TRAVEL_SAT;
            r.took = 1'b1;
            r.car = CAR_OUT_W'(pick);
            r.from_floor = car_at[pick];
            r.car_total = sum[TRAVEL_BITS-1:0];
            car_miles[pick] = sum[TRAVEL_BITS-1:0];
            car_at[pick] = d;
        end
        low = 0;
        for (int i = 1; i < n; i++)
            if (car_miles[i] < car_miles[low])
                low = i;
        r.low_car = CAR_OUT_W'(low);
        r.low_total = car_miles[low];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", what, got, want));
    endtask

    // result checker: done cannot be stalled, so every strobe is a beat
    always @(posedge clk)
    begin
        dispatch_t want;
        if (rst_n && done)
        begin
            if (dispatch_q.size() == 0)
                report_mismatch("result beat with nothing outstanding");
            else
            begin
                want = dispatch_q.pop_front();
                if (want.took)
                    n_taken++;
                else
                    n_refused++;
                check_field("accepted", accepted, want.took);
                check_field("chosen_car", chosen_car, want.car);
                check_field("start_floor", start_floor, want.from_floor);
                check_field("car_travel", car_travel, want.car_total);
                check_field("least_travel_car", least_travel_car, want.low_car);
                check_field("least_travel", least_travel, want.low_total);
            end
        end
    end

    function automatic int draw_gap();
        int x;
        if (burst_mode)
            return 0;
        x = $urandom_range(0, 99);
        if (x < 55)
            return 0;
        if (x < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(input logic [FLOOR_BITS-1:0] o,
                                input logic [FLOOR_BITS-1:0] d);
        int gap;
        start <= 1'b1;
        origin_floor <= o;
        dest_floor <= d;
        do
            @(posedge clk);
        while (busy);
        dispatch_q = {dispatch_q, predict_dispatch(o, d)};
        n_sent++;
        gap = draw_gap();
        holding = (gap == 0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (holding)
        begin
            start <= 1'b0;
            holding = 1'b0;
        end
        while (dispatch_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_TOP_FLOOR)
            top_reg = data[7:0];
        else if (addr == ADDR_CAR_COUNT)
            count_reg = data[3:0];
        n_writes++;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field($sformatf("prdata @%0h", addr), prdata, want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // only while idle
    task automatic configure(input logic [7:0] top, input logic [3:0] cnt);
        wait_idle();
        reg_write(ADDR_TOP_FLOOR, {24'($urandom), top});
        reg_check(ADDR_TOP_FLOOR, {24'h0, top});
        reg_write(ADDR_CAR_COUNT, {28'($urandom), cnt});
        reg_check(ADDR_CAR_COUNT, {28'h0, cnt});
    endtask

    task automatic test_request_limits();
        send_request(8'd0, 8'd255);
        send_request(8'd255, 8'd0);
        send_request(8'd0, 8'd0);
        send_request(8'd128, 8'd128);
        send_request(8'd255, 8'd255);
        send_request(8'd10, 8'd20);     // equal distance, less travel wins
        send_request(8'd170, 8'd85);
        send_request(8'd85, 8'd170);
        configure(8'd100, 4'd8);
        send_request(8'd101, 8'd0);
        send_request(8'd0, 8'd101);
        send_request(8'd100, 8'd0);
        send_request(8'd0, 8'd100);
        send_request(8'd255, 8'd3);
        configure(8'd0, 4'd0);          // nothing valid, count 0 acts as 1
        send_request(8'd0, 8'd0);
        send_request(8'd0, 8'd1);
        send_request(8'd1, 8'd0);
        configure(8'd255, 4'd0);
        send_request(8'd3, 8'd200);
        send_request(8'd200, 8'd3);
        configure(8'd255, 4'd15);       // clamps to MAX_CARS
        send_request(8'd50, 8'd60);
        send_request(8'd60, 8'd50);
        configure(8'd255, 4'd9);
        send_request(8'd7, 8'd8);
    endtask

    task automatic test_random_traffic();
        logic [7:0] tops [9] = '{8'd255, 8'd7, 8'd255, 8'd1, 8'd31, 8'd0, 8'd0, 8'd255, 8'd3};
        logic [3:0] cnts [9] = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd0, 4'd8, 4'd0, 4'd5, 4'd8};
        int         lens [9] = '{200, 150, 100, 60, 150, 40, 150, 200, 100};
        logic [7:0] top;
        logic [7:0] o;
        logic [7:0] d;
        for (int p = 0; p < 9; p++)
        begin
            top = (p == 6) ? 8'($urandom_range(2, 254)) : tops[p];
            configure(top, (p == 6) ? 4'($urandom_range(0, 15)) : cnts[p]);
            burst_mode = (p % 3 == 2);
            for (int k = 0; k < lens[p]; k++)
            begin
                if (top != 0 && $urandom_range(0, 99) < 85)
                begin
                    o = 8'($urandom_range(0, top));
                    d = 8'($urandom_range(0, top - 1));
                    if (d >= o)
                        d++;
                end
                else
                begin
                    o = 8'($urandom);
                    d = ($urandom_range(0, 3) == 0) ? o : 8'($urandom);
                end
                send_request(o, d);
                if ($urandom_range(0, 59) == 0)
                    wait_idle();
            end
        end
        burst_mode = 1'b0;
    endtask

    // one car runs back-to-back full-height trips, then a second car joins
    task automatic test_long_trips();
        configure(8'd255, 4'd1);
        burst_mode = 1'b1;
        repeat (24) send_request(8'd0, 8'd255);
        burst_mode = 1'b0;
        configure(8'd255, 4'd2);
        send_request(8'd255, 8'd0);
        send_request(8'd0, 8'd128);
    endtask

    initial
    begin
        for (int i = 0; i < MAX_CARS; i++)
        begin
            car_at[i] = '0;
            car_miles[i] = '0;
        end
        top_reg = 8'd255;
        count_reg = 4'd8;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_limits();
        test_random_traffic();
        test_long_trips();
        wait_idle();
        repeat (40) @(posedge clk);
        $display("ran %0d ride requests: %0d dispatched, %0d refused, %0d register writes",
                 n_sent, n_taken, n_refused, n_writes);
        $display("covered floor limits, car count clamping, tie breaks and long full-height trips");
        if (n_errors == 0)
            $display("elevator_nearest_car_dispatch_test: clean");
        else
            $display("elevator_nearest_car_dispatch_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/encd_pkg.sv
design/encd_cell.sv
design/elevator_nearest_car_dispatch.sv
design/encd_checker.sv
verif/elevator_nearest_car_dispatch_test.sv
